FILE: design/hav_pkg.sv
// package: constants, types and functions shared by the haversine distance design
`default_nettype none
package hav_pkg;

   localparam int FracBitsDefault = 30;
   localparam int CordicStagesDefault = 28;
   localparam int AtanEntries = 40;
   localparam int AngleBits = 38;
   localparam logic signed [AngleBits-1:0] TurnUnits = 38'sd36000000000;
   localparam logic signed [AngleBits-1:0] HalfTurn = 38'sd18000000000;
   localparam logic signed [AngleBits-1:0] QuarterTurn = 38'sd9000000000;
   localparam logic [63:0] GainQ62 = 64'd2800459870030031304;
   localparam logic [32:0] ScaleQ64 = 33'd6439128407;
   localparam logic [25:0] DistMax = 26'd67108863;
   localparam logic [23:0] RadiusReset = 24'd3963000;
   localparam logic [0:0] RegSphereRadius = 1'b0;

   typedef logic signed [AngleBits-1:0] angle_type;

   function automatic angle_type atan_entry(input int idx);
      angle_type r;
      r = '0;
      case (idx)
         0: r = 38'sd4500000000;
         1: r = 38'sd2656505118;
         2: r = 38'sd1403624347;
         3: r = 38'sd712501635;
         4: r = 38'sd357633437;
         5: r = 38'sd178991061;
         6: r = 38'sd89517371;
         7: r = 38'sd44761417;
         8: r = 38'sd22381050;
         9: r = 38'sd11190568;
         10: r = 38'sd5595289;
         11: r = 38'sd2797645;
         12: r = 38'sd1398823;
         13: r = 38'sd699411;
         14: r = 38'sd349706;
         15: r = 38'sd174853;
         16: r = 38'sd87426;
         17: r = 38'sd43713;
         18: r = 38'sd21857;
         19: r = 38'sd10928;
         20: r = 38'sd5464;
         21: r = 38'sd2732;
         22: r = 38'sd1366;
         23: r = 38'sd683;
         24: r = 38'sd342;
         25: r = 38'sd171;
         26: r = 38'sd85;
         27: r = 38'sd43;
         28: r = 38'sd21;
         29: r = 38'sd11;
         30: r = 38'sd5;
         31: r = 38'sd3;
         32: r = 38'sd1;
         33: r = 38'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: design/hav_cell.sv
// cordic cell: one micro-rotation stage, rotation or vectoring mode, with side data
`default_nettype none
module hav_cell #(
   parameter int Width = 34,
   parameter int Shift = 0,
   parameter int SideWidth = 1,
   parameter bit Vectoring = 1'b0
) (
   input  wire logic clock,
   input  wire logic enable,
   input  wire logic signed [Width-1:0] x_in,
   input  wire logic signed [Width-1:0] y_in,
   input  wire hav_pkg::angle_type z_in,
   input  wire logic [SideWidth-1:0] side_in,
   output logic signed [Width-1:0] x_out,
   output logic signed [Width-1:0] y_out,
   output hav_pkg::angle_type z_out,
   output logic [SideWidth-1:0] side_out
);
   import hav_pkg::*;

   logic signed [Width-1:0] x_ff, y_ff, x_in_n, y_in_n, dx, dy;
   angle_type z_ff, z_in_n, step;
   logic [SideWidth-1:0] side_ff;
   logic up;

   assign dx = x_in >>> Shift;
   assign dy = y_in >>> Shift;
   assign step = atan_entry(Shift);
   assign up = Vectoring ? (y_in >= 0) : (z_in >= 0);

   always_comb begin
      if (up != Vectoring) begin
         x_in_n = x_in - dy;
         y_in_n = y_in + dx;
      end else begin
         x_in_n = x_in + dy;
         y_in_n = y_in - dx;
      end
      if (up) z_in_n = Vectoring ? z_in + step : z_in - step;
      else z_in_n = Vectoring ? z_in - step : z_in + step;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in_n;
         y_ff <= y_in_n;
         z_ff <= z_in_n;
         side_ff <= side_in;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
   assign side_out = side_ff;
endmodule
`default_nettype wire

FILE: design/hav_sqrt_cell.sv
// square root cell: decides one result bit per stage
`default_nettype none
module hav_sqrt_cell #(
   parameter int RootBits = 31,
   parameter int Bit = 0,
   parameter int SideWidth = 1
) (
   input  wire logic clock,
   input  wire logic enable,
   input  wire logic [2*RootBits-1:0] n_in,
   input  wire logic [RootBits-1:0] r_in,
   input  wire logic [SideWidth-1:0] side_in,
   output logic [2*RootBits-1:0] n_out,
   output logic [RootBits-1:0] r_out,
   output logic [SideWidth-1:0] side_out
);
   logic [2*RootBits-1:0] n_ff;
   logic [RootBits-1:0] r_ff, t;
   logic [SideWidth-1:0] side_ff;
   logic [2*RootBits-1:0] sq;

   assign t = r_in | (RootBits'(1) << Bit);
   assign sq = t * t;

   always_ff @(posedge clock) begin
      if (enable) begin
         n_ff <= n_in;
         r_ff <= (sq <= n_in) ? t : r_in;
         side_ff <= side_in;
      end
   end

   assign n_out = n_ff;
   assign r_out = r_ff;
   assign side_out = side_ff;
endmodule
`default_nettype wire

FILE: design/haversine_distance.sv
// top level: pipelined haversine great-circle distance
`default_nettype none
// One item enters per cycle while the pipeline advances; each item passes through
// 1 reduction stage, CORDIC_STAGES sin/cos cells, 2 product stages, a clamp stage,
// FRAC_BITS+1 square-root cells, CORDIC_STAGES vectoring cells and 4 scaling stages.
// The whole pipeline advances only when the output register is empty or being taken,
// so req_stall follows rsp_stall while a result waits. The radius register is read
// by the scaling stages and should be written only when the pipeline is empty.
module haversine_distance #(
   parameter int FRAC_BITS = hav_pkg::FracBitsDefault,
   parameter int CORDIC_STAGES = hav_pkg::CordicStagesDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic signed [30:0] req_lat_a,
   input  wire logic signed [31:0] req_lon_a,
   input  wire logic signed [30:0] req_lat_b,
   input  wire logic signed [31:0] req_lon_b,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic [25:0] rsp_distance_milli,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import hav_pkg::*;

   localparam int W = FRAC_BITS + 4;
   localparam int RB = FRAC_BITS + 1;
   localparam int Depth = 1 + CORDIC_STAGES + 3 + RB + CORDIC_STAGES + 4;
   localparam logic signed [W-1:0] One = W'(1) <<< FRAC_BITS;
   localparam logic [63:0] GainRound =
      (GainQ62 + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);

   logic [23:0] radius_ff;
   logic [Depth-1:0] vld_ff;
   logic adv;

   assign adv = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[Depth-1];
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[1:1] == RegSphereRadius) ? {8'd0, radius_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RadiusReset;
         vld_ff <= '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:1] == RegSphereRadius)
            radius_ff <= csr_pwdata[23:0];
         if (adv) vld_ff <= {vld_ff[Depth-2:0], req_valid};
      end
   end

   // angle reduction into [-90, 90] degrees, top bit flags a cos sign flip
   // every input angle lies within one turn, so no modulo is needed
   function automatic logic [AngleBits:0] reduce(input logic signed [40:0] a);
      logic signed [40:0] m;
      logic flip;
      m = a;
      if (m >= 41'(HalfTurn)) m = m - 41'(TurnUnits);
      if (m < -41'(HalfTurn)) m = m + 41'(TurnUnits);
      flip = 1'b0;
      if (m > 41'(QuarterTurn)) begin
         m = 41'(HalfTurn) - m;
         flip = 1'b1;
      end else if (m < -41'(QuarterTurn)) begin
         m = -41'(HalfTurn) - m;
         flip = 1'b1;
      end
      return {flip, AngleBits'(m)};
   endfunction

   logic [AngleBits:0] red_in [4];
   assign red_in[0] = reduce(41'(41'(req_lat_b) - 41'(req_lat_a)) * 41'sd5);
   assign red_in[1] = reduce(41'(41'(req_lon_b) - 41'(req_lon_a)) * 41'sd5);
   assign red_in[2] = reduce(41'(req_lat_a) * 41'sd10);
   assign red_in[3] = reduce(41'(req_lat_b) * 41'sd10);

   angle_type ang_ff [4];
   logic [3:0] flip_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            ang_ff[k] <= angle_type'(red_in[k][AngleBits-1:0]);
            flip_ff[k] <= red_in[k][AngleBits];
         end
      end
   end

   logic signed [W-1:0] sx [4][CORDIC_STAGES+1];
   logic signed [W-1:0] sy [4][CORDIC_STAGES+1];
   angle_type sz [4][CORDIC_STAGES+1];
   logic sf [4][CORDIC_STAGES+1];

   for (genvar k = 0; k < 4; k++) begin : g_rot
      assign sx[k][0] = W'(GainRound);
      assign sy[k][0] = '0;
      assign sz[k][0] = ang_ff[k];
      assign sf[k][0] = flip_ff[k];
      for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
         hav_cell #(.Width(W), .Shift(i), .SideWidth(1), .Vectoring(1'b0)) u_cell (
            .clock(clock), .enable(adv),
            .x_in(sx[k][i]), .y_in(sy[k][i]), .z_in(sz[k][i]), .side_in(sf[k][i]),
            .x_out(sx[k][i+1]), .y_out(sy[k][i+1]), .z_out(sz[k][i+1]),
            .side_out(sf[k][i+1])
         );
      end
   end

   // rounded signed product, half away from zero
   function automatic logic signed [W-1:0] mulq(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
      logic [W-1:0] ma, mb;
      logic [2*W-1:0] p;
      logic [W-1:0] r;
      ma = a[W-1] ? W'(-a) : W'(a);
      mb = b[W-1] ? W'(-b) : W'(b);
      p = ma * mb + ((2*W)'(1) << (FRAC_BITS - 1));
      r = W'(p >> FRAC_BITS);
      return (a[W-1] != b[W-1]) ? -$signed(r) : $signed(r);
   endfunction

   logic signed [W-1:0] c_a, c_b;
   assign c_a = sf[2][CORDIC_STAGES] ? -sx[2][CORDIC_STAGES] : sx[2][CORDIC_STAGES];
   assign c_b = sf[3][CORDIC_STAGES] ? -sx[3][CORDIC_STAGES] : sx[3][CORDIC_STAGES];

   logic signed [W-1:0] p1_ff, pc_ff, ps_ff, p2_ff, p3_ff, h_ff;
   logic signed [W:0] hs;
   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff <= mulq(sy[0][CORDIC_STAGES], sy[0][CORDIC_STAGES]);
         pc_ff <= mulq(c_a, c_b);
         ps_ff <= mulq(sy[1][CORDIC_STAGES], sy[1][CORDIC_STAGES]);
         p2_ff <= mulq(pc_ff, ps_ff);
         p3_ff <= p1_ff;
         h_ff <= (hs < 0) ? '0 : ((hs > (W+1)'(One)) ? One : W'(hs));
      end
   end
   assign hs = (W+1)'(p3_ff) + (W+1)'(p2_ff);

   logic [2*RB-1:0] nh [RB+1], nc [RB+1];
   logic [RB-1:0] rh [RB+1], rc [RB+1];
   assign nh[0] = (2*RB)'(h_ff) << FRAC_BITS;
   assign nc[0] = (2*RB)'(One - h_ff) << FRAC_BITS;
   assign rh[0] = '0;
   assign rc[0] = '0;
   for (genvar j = 0; j < RB; j++) begin : g_sqrt
      hav_sqrt_cell #(.RootBits(RB), .Bit(RB-1-j), .SideWidth(1)) u_h (
         .clock(clock), .enable(adv), .n_in(nh[j]), .r_in(rh[j]), .side_in(1'b0),
         .n_out(nh[j+1]), .r_out(rh[j+1]), .side_out()
      );
      hav_sqrt_cell #(.RootBits(RB), .Bit(RB-1-j), .SideWidth(1)) u_c (
         .clock(clock), .enable(adv), .n_in(nc[j]), .r_in(rc[j]), .side_in(1'b0),
         .n_out(nc[j+1]), .r_out(rc[j+1]), .side_out()
      );
   end

   logic signed [W-1:0] vx [CORDIC_STAGES+1], vy [CORDIC_STAGES+1];
   angle_type vz [CORDIC_STAGES+1];
   assign vx[0] = W'(rc[RB]);
   assign vy[0] = W'(rh[RB]);
   assign vz[0] = '0;
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
      hav_cell #(.Width(W), .Shift(i), .SideWidth(1), .Vectoring(1'b1)) u_cell (
         .clock(clock), .enable(adv), .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]),
         .side_in(1'b0), .x_out(vx[i+1]), .y_out(vy[i+1]), .z_out(vz[i+1]), .side_out()
      );
   end

   // radius times angle is split in two halves for the scale multiply
   logic [33:0] zc_ff;
   logic [57:0] rz_ff;
   logic [64:0] pl_ff;
   logic [58:0] ph_ff;
   logic [90:0] prod;
   logic [26:0] d;
   logic [25:0] dist_ff;
   assign prod = {ph_ff, 32'd0} + 91'(pl_ff);
   assign d = 27'(prod[90:64]) + 27'(prod[63]);
   always_ff @(posedge clock) begin
      if (adv) begin
         zc_ff <= (vz[CORDIC_STAGES] < 0) ? '0 :
                  ((vz[CORDIC_STAGES] > QuarterTurn) ? 34'(QuarterTurn)
                                                     : 34'(vz[CORDIC_STAGES]));
         rz_ff <= 58'(radius_ff) * 58'(zc_ff);
         pl_ff <= 65'(rz_ff[31:0]) * 65'(ScaleQ64);
         ph_ff <= 59'(rz_ff[57:32]) * 59'(ScaleQ64);
         dist_ff <= (d > 27'(DistMax)) ? DistMax : d[25:0];
      end
   end
   assign rsp_distance_milli = dist_ff;
endmodule
`default_nettype wire

FILE: design/hav_checker.sv
// checker: port-level properties of the haversine distance block
`default_nettype none
module hav_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic [25:0] rsp_distance_milli,
   input wire logic csr_pready
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_distance_milli))
      else $error("held result changed");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output blocked");
   a_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("stall with empty output");
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result after reset");
   a_rdy: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
endmodule

bind haversine_distance hav_checker u_hav_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_distance_milli(rsp_distance_milli), .csr_pready(csr_pready)
);
`default_nettype wire
